// File: design/mdio_clause22_frame_master_top_defines.svh
// ----------------------------------------------------------------------------
// MDIO Clause 22 frame master: assertion macros
// Shared concurrent assertion forms, all disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MDIO_CLAUSE22_FRAME_MASTER_TOP_DEFINES_SVH
`define MDIO_CLAUSE22_FRAME_MASTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MDIO_C22_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MDIO_C22_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/mdio_c22_pkg.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 package
// Command codes, frame phases, frame constants and the request/result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdio_c22_pkg;

   // Command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // Frame phases, one-hot
   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_PRE  = 6'b000010,
      PH_HDR  = 6'b000100,
      PH_TA   = 6'b001000,
      PH_DATA = 6'b010000,
      PH_END  = 6'b100000
   } phase_type;

   // Bit counts per phase
   localparam logic [5:0] MAX_PREAMBLE = 6'd32;
   localparam logic [5:0] HDR_BITS     = 6'd14;
   localparam logic [5:0] TA_BITS      = 6'd2;
   localparam logic [5:0] DATA_BITS    = 6'd16;
   localparam logic [5:0] END_BITS     = 6'd1;

   // Start plus opcode, and the write turnaround
   localparam logic [3:0] READ_HEAD  = 4'b0110;
   localparam logic [3:0] WRITE_HEAD = 4'b0101;
   localparam logic [1:0] WRITE_TA   = 2'b10;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  phy_address;
      logic [4:0]  register_address;
      logic [15:0] write_value;
      logic        mdio_in;
   } req_type;

   typedef struct packed {
      logic        mdc;
      logic        mdio_out;
      logic        mdio_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_value;
   } res_type;

endpackage

// File: design/mdio_clause22_frame_master_top.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 frame master
// Input register, frame sequencer and result register.
// ----------------------------------------------------------------------------
// Usage: every request on req_ is one half period of the management clock.
// req_cmd starts a read or a write from idle; it is ignored during a frame.
// Each request yields exactly one response on rsp_ carrying the clock level,
// the data line level and drive enable, busy/done flags and the last read
// value. The line is driven from these response fields by the user.
// Path: an accepted request is held in the input register and reaches rsp_
// through the result register when that register is free.
// Throughput: one request per cycle; the sequencer handles one tick per cycle
// between the input register and the result register.
// Stall: while rsp_stall holds a waiting response, one more request is taken
// into the input register, then req_stall rises until the response leaves.
// Reset (synchronous, active high) empties both registers, returns the frame
// to idle, clears the last read value and sets the preamble length to 32.
// csr_write_data sets the preamble length; write it only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mdio_clause22_frame_master_top_defines.svh"

module mdio_clause22_frame_master_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_phy_address,
   input  logic [4:0]  req_register_address,
   input  logic [15:0] req_write_value,
   input  logic        req_mdio_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_mdc,
   output logic        rsp_mdio_out,
   output logic        rsp_mdio_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [15:0] rsp_read_value,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data
);
   import mdio_c22_pkg::*;

   logic    in_valid_ff;
   req_type in_req_ff;
   logic    rsp_valid_ff;
   res_type rsp_ff;
   res_type seq_res;
   logic    advance;
   logic    accept;

   // Move the held request forward when the result register frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= '{cmd: req_cmd, phy_address: req_phy_address,
                        register_address: req_register_address,
                        write_value: req_write_value, mdio_in: req_mdio_in};
      end
   end

   mdio_c22_frame_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .fire             (advance),
      .req              (in_req_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .res              (seq_res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= seq_res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mdc        = rsp_ff.mdc;
   assign rsp_mdio_out   = rsp_ff.mdio_out;
   assign rsp_mdio_drive = rsp_ff.mdio_drive;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_read_value = rsp_ff.read_value;

   `MDIO_C22_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff,
      "advanced request produced no response")
   `MDIO_C22_ASSERT_NEXT(a_blocked_req_kept, clock, reset, in_valid_ff && !advance,
      in_valid_ff, "blocked request was dropped")
   `MDIO_C22_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      in_valid_ff && rsp_valid_ff && rsp_stall, "input stalled with room to move")

endmodule

// File: design/mdio_c22_frame_seq.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 frame sequencer
// Holds the frame state and computes one half-period tick per fired request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mdio_clause22_frame_master_top_defines.svh"

module mdio_c22_frame_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  mdio_c22_pkg::req_type req,
   input  logic                  csr_write_enable,
   input  logic [5:0]            csr_write_data,
   output mdio_c22_pkg::res_type res
);
   import mdio_c22_pkg::*;

   logic [5:0]  preamble_ff;
   phase_type   phase_ff, phase_in;
   logic [5:0]  count_ff, count_in;
   logic        half_ff, half_in;
   logic        is_read_ff, is_read_in;
   logic [31:0] out_shift_ff, out_shift_in;
   logic [15:0] in_shift_ff, in_shift_in;
   logic [15:0] last_read_ff, last_read_in;

   // Compute the tick: optional frame start, then one half period
   always_comb begin
      logic       start;
      logic [5:0] pre;
      logic [5:0] dec;
      phase_type  ph;
      start        = (phase_ff == PH_IDLE) && (req.cmd == CMD_READ || req.cmd == CMD_WRITE);
      pre          = (preamble_ff > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_ff;
      dec          = '0;
      phase_in     = phase_ff;
      count_in     = count_ff;
      half_in      = half_ff;
      is_read_in   = is_read_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      last_read_in = last_read_ff;
      res          = '0;

      // Load a new frame
      if (start) begin
         is_read_in = (req.cmd == CMD_READ);
         if (req.cmd == CMD_READ) begin
            out_shift_in = {READ_HEAD, req.phy_address, req.register_address, 18'd0};
         end else begin
            out_shift_in = {WRITE_HEAD, req.phy_address, req.register_address, WRITE_TA,
                            req.write_value};
         end
         half_in     = 1'b0;
         in_shift_in = '0;
         if (pre == 6'd0) begin
            phase_in = PH_HDR;
            count_in = HDR_BITS;
         end else begin
            phase_in = PH_PRE;
            count_in = pre;
         end
      end

      ph = phase_in;
      if (ph != PH_IDLE) begin
         res.busy_res = 1'b1;
         res.mdc      = half_in;
         if (ph == PH_PRE) begin
            res.mdio_drive = 1'b1;
            res.mdio_out   = 1'b1;
         end else if (ph == PH_HDR || ((ph == PH_TA || ph == PH_DATA) && !is_read_in)) begin
            res.mdio_drive = 1'b1;
            res.mdio_out   = out_shift_in[31];
         end

         // Low half: raise the clock. High half: advance one bit.
         if (!half_in) begin
            half_in = 1'b1;
         end else begin
            half_in = 1'b0;
            if (ph == PH_HDR || ph == PH_TA || ph == PH_DATA) begin
               out_shift_in = {out_shift_in[30:0], 1'b0};
            end
            if (ph == PH_DATA && is_read_in) begin
               in_shift_in = {in_shift_in[14:0], req.mdio_in};
            end
            dec = (count_in != 6'd0) ? count_in - 6'd1 : count_in;
            count_in = dec;
            if (dec == 6'd0) begin
               case (ph)
                  PH_PRE: begin
                     phase_in = PH_HDR;
                     count_in = HDR_BITS;
                  end
                  PH_HDR: begin
                     phase_in = PH_TA;
                     count_in = TA_BITS;
                  end
                  PH_TA: begin
                     phase_in = PH_DATA;
                     count_in = DATA_BITS;
                  end
                  PH_DATA: begin
                     if (is_read_in) begin
                        last_read_in = in_shift_in;
                     end
                     phase_in = PH_END;
                     count_in = END_BITS;
                  end
                  default: begin
                     res.done_res = 1'b1;
                     phase_in     = PH_IDLE;
                     count_in     = 6'd0;
                  end
               endcase
            end
         end
      end else begin
         phase_in = PH_IDLE;
         half_in  = 1'b0;
      end
      res.read_value = last_read_in;
   end

   // Hold state between fired requests
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff  <= MAX_PREAMBLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         half_ff      <= 1'b0;
         is_read_ff   <= 1'b0;
         out_shift_ff <= '0;
         in_shift_ff  <= '0;
         last_read_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            preamble_ff <= csr_write_data;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            half_ff      <= half_in;
            is_read_ff   <= is_read_in;
            out_shift_ff <= out_shift_in;
            in_shift_ff  <= in_shift_in;
            last_read_ff <= last_read_in;
         end
      end
   end

   `MDIO_C22_ASSERT_NOW(a_done_in_frame, clock, reset, res.done_res, res.busy_res,
      "done outside a frame")
   `MDIO_C22_ASSERT_NOW(a_out_needs_drive, clock, reset, res.mdio_out, res.mdio_drive,
      "data driven high while line released")
   `MDIO_C22_ASSERT_NEXT(a_end_to_idle, clock, reset,
      fire && phase_ff == PH_END && half_ff, phase_ff == PH_IDLE,
      "frame did not close after the trailing clock")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 frame master testbench
// Walks a short table of read and write frames across the preamble settings.
// Then it runs random frames with random line data and noise commands while
// both handshakes idle in bursts. Every response is checked against a table
// value or a cycle model of the frame sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import mdio_c22_pkg::*;

   localparam logic [1:0] CMD_SPARE  = 2'd3;   // unused code, acts as a plain tick
   localparam int ITEM_GOAL          = 1500;
   localparam int CALM_TAIL          = 200;
   localparam int DRAIN_CYCLES       = 4;
   localparam int STUCK_LIMIT        = 2000;

   typedef struct {
      int          cfg;        // preamble length to load first, -1 keeps it
      logic [1:0]  cmd;
      logic [4:0]  phy;
      logic [4:0]  rnum;
      logic [15:0] wval;
      logic [15:0] line_bits;  // data the device returns on a read
      bit          typed;
      res_type     want;       // first response, when typed
   } plan_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd          = CMD_TICK;
   logic [4:0]  req_phy_address  = 5'd0;
   logic [4:0]  req_register_address = 5'd0;
   logic [15:0] req_write_value  = 16'd0;
   logic        req_mdio_in      = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_mdc;
   logic        rsp_mdio_out;
   logic        rsp_mdio_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [15:0] rsp_read_value;
   logic        csr_write_enable = 1'b0;
   logic [5:0]  csr_write_data   = 6'd0;

   // Frame sequencer model state
   phase_type   frame_ph;
   logic [5:0]  bits_left;
   logic        half_high;
   logic        reading;
   logic [31:0] tx_shift;
   logic [15:0] rx_shift;
   logic [15:0] read_hold;
   logic [5:0]  preamble_len;

   res_type     tick_expect_q[$];
   plan_row_type plan[$];

   int          mismatches      = 0;
   int          items           = 0;
   int          responses       = 0;
   int          read_frames     = 0;
   int          write_frames    = 0;
   int          preamble_loads  = 0;
   int          stuck_cycles    = 0;
   int          stall_left      = 0;
   bit          quiet           = 1'b0;
   bit          sender_gaps     = 1'b1;
   bit          receiver_stalls = 1'b1;

   mdio_clause22_frame_master_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_phy_address      (req_phy_address),
      .req_register_address (req_register_address),
      .req_write_value      (req_write_value),
      .req_mdio_in          (req_mdio_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_mdc              (rsp_mdc),
      .rsp_mdio_out         (rsp_mdio_out),
      .rsp_mdio_drive       (rsp_mdio_drive),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_value       (rsp_read_value),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic res_type tick_out(bit mdc, bit dout, bit drive, bit busy,
                                        bit done, logic [15:0] rv);
      res_type o;
      o.mdc        = mdc;
      o.mdio_out   = dout;
      o.mdio_drive = drive;
      o.busy_res   = busy;
      o.done_res   = done;
      o.read_value = rv;
      return o;
   endfunction

   // Advance the frame model by one half period and return the line levels
   function automatic res_type mdio_tick_predict(req_type r);
      res_type    o;
      logic [5:0] pre;
      phase_type  ph;
      o = '0;
      // Start a frame only from idle
      if (frame_ph == PH_IDLE && (r.cmd == CMD_READ || r.cmd == CMD_WRITE)) begin
         pre = (preamble_len > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_len;
         reading = (r.cmd == CMD_READ);
         if (reading)
            tx_shift = {READ_HEAD, r.phy_address, r.register_address, 18'd0};
         else
            tx_shift = {WRITE_HEAD, r.phy_address, r.register_address, WRITE_TA,
                        r.write_value};
         half_high = 1'b0;
         rx_shift  = 16'd0;
         if (pre == 6'd0) begin
            frame_ph  = PH_HDR;
            bits_left = HDR_BITS;
         end else begin
            frame_ph  = PH_PRE;
            bits_left = pre;
         end
      end
      if (frame_ph != PH_IDLE) begin
         ph = frame_ph;
         o.busy_res = 1'b1;
         o.mdc      = half_high;
         if (ph == PH_PRE) begin
            o.mdio_drive = 1'b1;
            o.mdio_out   = 1'b1;
         end else if (ph == PH_HDR || ((ph == PH_TA || ph == PH_DATA) && !reading)) begin
            o.mdio_drive = 1'b1;
            o.mdio_out   = tx_shift[31];
         end
         if (!half_high) begin
            half_high = 1'b1;
         end else begin
            // High half closes the bit: shift, sample, count down
            half_high = 1'b0;
            if (ph == PH_HDR || ph == PH_TA || ph == PH_DATA)
               tx_shift = tx_shift << 1;
            if (ph == PH_DATA && reading)
               rx_shift = {rx_shift[14:0], r.mdio_in};
            if (bits_left != 6'd0)
               bits_left = bits_left - 6'd1;
            if (bits_left == 6'd0) begin
               case (ph)
                  PH_PRE: begin
                     frame_ph  = PH_HDR;
                     bits_left = HDR_BITS;
                  end
                  PH_HDR: begin
                     frame_ph  = PH_TA;
                     bits_left = TA_BITS;
                  end
                  PH_TA: begin
                     frame_ph  = PH_DATA;
                     bits_left = DATA_BITS;
                  end
                  PH_DATA: begin
                     if (reading)
                        read_hold = rx_shift;
                     frame_ph  = PH_END;
                     bits_left = END_BITS;
                  end
                  default: begin
                     o.done_res = 1'b1;
                     frame_ph   = PH_IDLE;
                     bits_left  = 6'd0;
                  end
               endcase
            end
         end
      end else begin
         half_high = 1'b0;
      end
      o.read_value = read_hold;
      return o;
   endfunction

   // Offer one request, wait for the handshake, then record its response
   task automatic push_request(req_type r, bit typed, res_type want);
      res_type guess;
      if ($urandom_range(0, 99) == 0)
         sender_gaps = !sender_gaps;
      if (!quiet && sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_cmd              <= r.cmd;
      req_phy_address      <= r.phy_address;
      req_register_address <= r.register_address;
      req_write_value      <= r.write_value;
      req_mdio_in          <= r.mdio_in;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      guess = mdio_tick_predict(r);
      tick_expect_q.push_back(typed ? want : guess);
      items++;
   endtask

   // Send one command, then plain ticks with noise until the frame is over
   task automatic run_command(logic [1:0] op, logic [4:0] phy, logic [4:0] rnum,
                              logic [15:0] wval, logic [15:0] line_bits,
                              bit typed, res_type want);
      req_type r;
      r.cmd              = op;
      r.phy_address      = phy;
      r.register_address = rnum;
      r.write_value      = wval;
      r.mdio_in          = 1'($urandom_range(0, 1));
      if (op == CMD_READ)
         read_frames++;
      else if (op == CMD_WRITE)
         write_frames++;
      push_request(r, typed, want);
      while (frame_ph != PH_IDLE) begin
         r.cmd              = 2'($urandom_range(0, 3));
         r.phy_address      = 5'($urandom);
         r.register_address = 5'($urandom);
         r.write_value      = 16'($urandom);
         if (frame_ph == PH_DATA && reading)
            r.mdio_in = line_bits[bits_left - 6'd1];
         else
            r.mdio_in = 1'($urandom_range(0, 1));
         push_request(r, 1'b0, '0);
      end
   endtask

   // Drain the block, then load a new preamble length
   task automatic set_preamble(logic [5:0] value);
      req_valid <= 1'b0;
      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      preamble_len = value;
      preamble_loads++;
   endtask

   function automatic plan_row_type plan_row(int cfg, logic [1:0] cmd, logic [4:0] phy,
                                             logic [4:0] rnum, logic [15:0] wval,
                                             logic [15:0] line_bits, bit typed,
                                             res_type want);
      plan_row_type p;
      p.cfg       = cfg;
      p.cmd       = cmd;
      p.phy       = phy;
      p.rnum      = rnum;
      p.wval      = wval;
      p.line_bits = line_bits;
      p.typed     = typed;
      p.want      = want;
      return p;
   endfunction

   task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("mismatch: response %0d field %s got %h want %h", responses, field, got,
               want);
      mismatches++;
   endtask

   // Receiver: stall in bursts, with stretches of none
   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0)
         receiver_stalls <= !receiver_stalls;
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tick_expect_q.size() == 0) begin
            report_mismatch("unexpected", 16'd0, 16'd0);
         end else begin
            if (rsp_mdc !== tick_expect_q[0].mdc)
               report_mismatch("mdc", rsp_mdc, tick_expect_q[0].mdc);
            if (rsp_mdio_out !== tick_expect_q[0].mdio_out)
               report_mismatch("mdio_out", rsp_mdio_out, tick_expect_q[0].mdio_out);
            if (rsp_mdio_drive !== tick_expect_q[0].mdio_drive)
               report_mismatch("mdio_drive", rsp_mdio_drive, tick_expect_q[0].mdio_drive);
            if (rsp_busy_res !== tick_expect_q[0].busy_res)
               report_mismatch("busy_res", rsp_busy_res, tick_expect_q[0].busy_res);
            if (rsp_done_res !== tick_expect_q[0].done_res)
               report_mismatch("done_res", rsp_done_res, tick_expect_q[0].done_res);
            if (rsp_read_value !== tick_expect_q[0].read_value)
               report_mismatch("read_value", rsp_read_value, tick_expect_q[0].read_value);
            void'(tick_expect_q.pop_front());
         end
         responses++;
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int          frames_since_load;
      logic [1:0]  op;
      logic [5:0]  pick;
      plan_row_type p;

      frame_ph     = PH_IDLE;
      bits_left    = 6'd0;
      half_high    = 1'b0;
      reading      = 1'b0;
      tx_shift     = 32'd0;
      rx_shift     = 16'd0;
      read_hold    = 16'd0;
      preamble_len = MAX_PREAMBLE;
      frames_since_load = 0;

      // Directed frames: extremes of addresses, data and preamble length
      plan.push_back(plan_row(-1, CMD_TICK, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b1,
                              tick_out(0, 0, 0, 0, 0, 16'h0000)));
      plan.push_back(plan_row(-1, CMD_SPARE, 5'd31, 5'd31, 16'hFFFF, 16'h0000, 1'b1,
                              tick_out(0, 0, 0, 0, 0, 16'h0000)));
      plan.push_back(plan_row(-1, CMD_WRITE, 5'd31, 5'd31, 16'hFFFF, 16'h0000, 1'b1,
                              tick_out(0, 1, 1, 1, 0, 16'h0000)));
      plan.push_back(plan_row(-1, CMD_READ, 5'd0, 5'd0, 16'h0000, 16'hFFFF, 1'b0, '0));
      plan.push_back(plan_row(0, CMD_WRITE, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b1,
                              tick_out(0, 0, 1, 1, 0, 16'hFFFF)));
      plan.push_back(plan_row(-1, CMD_READ, 5'd31, 5'd31, 16'hFFFF, 16'h0000, 1'b0, '0));
      plan.push_back(plan_row(-1, CMD_TICK, 5'd5, 5'd9, 16'h1234, 16'h0000, 1'b1,
                              tick_out(0, 0, 0, 0, 0, 16'h0000)));
      plan.push_back(plan_row(1, CMD_READ, 5'h15, 5'h0A, 16'h0000, 16'hA5A5, 1'b0, '0));
      plan.push_back(plan_row(63, CMD_WRITE, 5'h0A, 5'h15, 16'h5A5A, 16'h0000, 1'b0, '0));
      plan.push_back(plan_row(33, CMD_READ, 5'h1F, 5'h00, 16'h0000, 16'h8001, 1'b0, '0));
      plan.push_back(plan_row(-1, CMD_SPARE, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b1,
                              tick_out(0, 0, 0, 0, 0, 16'h8001)));
      plan.push_back(plan_row(32, CMD_WRITE, 5'h10, 5'h01, 16'h8001, 16'h0000, 1'b0, '0));
      plan.push_back(plan_row(2, CMD_READ, 5'h01, 5'h10, 16'h0000, 16'h7FFE, 1'b0, '0));

      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         p = plan[i];
         if (p.cfg >= 0)
            set_preamble(p.cfg[5:0]);
         run_command(p.cmd, p.phy, p.rnum, p.wval, p.line_bits, p.typed, p.want);
      end

      // Random frames, mostly short preambles, with noise ticks between them
      while (items < ITEM_GOAL) begin
         if (items >= ITEM_GOAL - CALM_TAIL)
            quiet = 1'b1;
         if (frames_since_load >= 3 && $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0:       pick = 6'd0;
               1:       pick = 6'd1;
               2:       pick = MAX_PREAMBLE;
               3:       pick = 6'd63;
               4:       pick = 6'($urandom_range(33, 62));
               default: pick = 6'($urandom_range(0, 6));
            endcase
            set_preamble(pick);
            frames_since_load = 0;
         end
         repeat ($urandom_range(0, 3))
            run_command($urandom_range(0, 1) ? CMD_SPARE : CMD_TICK, 5'($urandom),
                        5'($urandom), 16'($urandom), 16'h0000, 1'b0, '0);
         op = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
         run_command(op, 5'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
                     1'b0, '0);
         frames_since_load++;
      end

      // Let every response out, then keep watching for strays
      req_valid <= 1'b0;
      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);

      $display("covered %0d requests, %0d responses: %0d read and %0d write frames",
               items, responses, read_frames, write_frames);
      $display("preamble length loaded %0d times, including zero and saturating values",
               preamble_loads);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
